### hw/rtl/tsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster: shared types and constants
// Command codes, phase and controller state encodings, and the control and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int unsigned COLOR_W = 8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_SPAN  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_UPPER = 2'd1,
    PH_LOWER = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    PAIR_01 = 2'd0,
    PAIR_02 = 2'd1,
    PAIR_12 = 2'd2
  } pair_e;

  typedef enum logic {
    EDGE_LEFT  = 1'b0,
    EDGE_RIGHT = 1'b1
  } edge_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_A,
    ST_SORT_B,
    ST_SORT_C,
    ST_INIT,
    ST_WALK_L,
    ST_DIV_L,
    ST_WALK_R,
    ST_DIV_R,
    ST_ADV,
    ST_PHASE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic  load_start;
    logic  swap_en;
    pair_e swap_pair;
    logic  init;
    edge_e walk_edge;
    logic  walk_fast;
    logic  div_start;
    logic  walk_div;
    logic  advance;
    logic  phase_step;
    logic  stage_done;
    logic  emit;
  } tsr_ctl_t;

  typedef struct packed {
    logic active;
    logic need_walk;
    logic fast;
    logic div_done;
    logic out_free;
  } tsr_stat_t;

endpackage

### hw/rtl/tsr_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster: command channel
// Valid/ready channel carrying start and span commands with vertex data.
// ----------------------------------------------------------------------------
interface tsr_cmd_if #(
  parameter int unsigned COORD_BITS = 16
) ();

  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [tsr_pkg::COLOR_W-1:0]        color;
  logic signed [COORD_BITS-1:0]       ax;
  logic signed [COORD_BITS-1:0]       ay;
  logic signed [COORD_BITS-1:0]       bx;
  logic signed [COORD_BITS-1:0]       by_coord;
  logic signed [COORD_BITS-1:0]       cx;
  logic signed [COORD_BITS-1:0]       cy;

  modport source (
    output valid, cmd, color, ax, ay, bx, by_coord, cx, cy,
    input  ready
  );

  modport sink (
    input  valid, cmd, color, ax, ay, bx, by_coord, cx, cy,
    output ready
  );

endinterface

### hw/rtl/tsr_span_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster: span channel
// Valid/ready channel carrying one span or a done indication per item.
// ----------------------------------------------------------------------------
interface tsr_span_if #(
  parameter int unsigned COORD_BITS = 16
) ();

  logic                               valid;
  logic                               ready;
  logic signed [COORD_BITS-1:0]       span_x;
  logic signed [COORD_BITS-1:0]       span_y;
  logic [COORD_BITS-1:0]              span_width;
  logic [tsr_pkg::COLOR_W-1:0]        span_color;
  logic                               last_span;
  logic                               done_res;

  modport source (
    output valid, span_x, span_y, span_width, span_color, last_span, done_res,
    input  ready
  );

  modport sink (
    input  valid, span_x, span_y, span_width, span_color, last_span, done_res,
    output ready
  );

endinterface

### hw/rtl/tsr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster: edge step divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsr_div #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             last_step;

  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign diff      = trial - {1'b0, den_q};
  assign last_step = (cnt_q == CNT_W'(NUM_W - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    done_d = busy_q && last_step;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ~diff[DEN_W]};
      cnt_d = cnt_q + CNT_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/tsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster: controller
// Sequences vertex sorting, edge set-up, the left and right edge walks, row advance and
// result hand-off.
// ----------------------------------------------------------------------------
module tsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_ready_o,
  input  tsr_pkg::tsr_stat_t stat_i,
  output tsr_pkg::tsr_ctl_t  ctl_o
);

  tsr_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == tsr_pkg::CMD_START) begin
            state_d = tsr_pkg::ST_SORT_A;
          end else if (stat_i.active) begin
            state_d = tsr_pkg::ST_WALK_L;
          end else begin
            state_d = tsr_pkg::ST_EMIT;
          end
        end
      end
      tsr_pkg::ST_SORT_A: state_d = tsr_pkg::ST_SORT_B;
      tsr_pkg::ST_SORT_B: state_d = tsr_pkg::ST_SORT_C;
      tsr_pkg::ST_SORT_C: state_d = tsr_pkg::ST_INIT;
      tsr_pkg::ST_INIT:   state_d = tsr_pkg::ST_IDLE;
      tsr_pkg::ST_WALK_L: begin
        if (!stat_i.need_walk || stat_i.fast) begin
          state_d = tsr_pkg::ST_WALK_R;
        end else begin
          state_d = tsr_pkg::ST_DIV_L;
        end
      end
      tsr_pkg::ST_DIV_L: begin
        if (stat_i.div_done) begin
          state_d = tsr_pkg::ST_WALK_R;
        end
      end
      tsr_pkg::ST_WALK_R: begin
        if (!stat_i.need_walk || stat_i.fast) begin
          state_d = tsr_pkg::ST_ADV;
        end else begin
          state_d = tsr_pkg::ST_DIV_R;
        end
      end
      tsr_pkg::ST_DIV_R: begin
        if (stat_i.div_done) begin
          state_d = tsr_pkg::ST_ADV;
        end
      end
      tsr_pkg::ST_ADV:   state_d = tsr_pkg::ST_PHASE;
      tsr_pkg::ST_PHASE: state_d = tsr_pkg::ST_EMIT;
      tsr_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = tsr_pkg::ST_IDLE;
        end
      end
      default: state_d = tsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.walk_edge = tsr_pkg::EDGE_LEFT;
    ctl_o.swap_pair = tsr_pkg::PAIR_01;
    in_ready_o      = 1'b0;
    unique case (state_q)
      tsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == tsr_pkg::CMD_START) begin
            ctl_o.load_start = 1'b1;
          end else if (!stat_i.active) begin
            ctl_o.stage_done = 1'b1;
          end
        end
      end
      tsr_pkg::ST_SORT_A: begin
        ctl_o.swap_en   = 1'b1;
        ctl_o.swap_pair = tsr_pkg::PAIR_01;
      end
      tsr_pkg::ST_SORT_B: begin
        ctl_o.swap_en   = 1'b1;
        ctl_o.swap_pair = tsr_pkg::PAIR_02;
      end
      tsr_pkg::ST_SORT_C: begin
        ctl_o.swap_en   = 1'b1;
        ctl_o.swap_pair = tsr_pkg::PAIR_12;
      end
      tsr_pkg::ST_INIT: ctl_o.init = 1'b1;
      tsr_pkg::ST_WALK_L, tsr_pkg::ST_WALK_R: begin
        ctl_o.walk_edge = (state_q == tsr_pkg::ST_WALK_R) ? tsr_pkg::EDGE_RIGHT
                                                           : tsr_pkg::EDGE_LEFT;
        if (stat_i.need_walk) begin
          ctl_o.walk_fast = stat_i.fast;
          ctl_o.div_start = !stat_i.fast;
        end
      end
      tsr_pkg::ST_DIV_L, tsr_pkg::ST_DIV_R: begin
        ctl_o.walk_edge = (state_q == tsr_pkg::ST_DIV_R) ? tsr_pkg::EDGE_RIGHT
                                                          : tsr_pkg::EDGE_LEFT;
        ctl_o.walk_div  = stat_i.div_done;
      end
      tsr_pkg::ST_ADV:   ctl_o.advance    = 1'b1;
      tsr_pkg::ST_PHASE: ctl_o.phase_step = 1'b1;
      tsr_pkg::ST_EMIT:  ctl_o.emit       = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/tsr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster: datapath
// Vertex store and sort, Bresenham edge walkers with a shared divider, row
// and phase tracking, result staging and the output register.
// ----------------------------------------------------------------------------
module tsr_dpath #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsr_pkg::tsr_ctl_t             ctl_i,
  output tsr_pkg::tsr_stat_t            stat_o,
  input  logic [tsr_pkg::COLOR_W-1:0]   color_i,
  input  logic signed [COORD_BITS-1:0]  ax_i,
  input  logic signed [COORD_BITS-1:0]  ay_i,
  input  logic signed [COORD_BITS-1:0]  bx_i,
  input  logic signed [COORD_BITS-1:0]  by_i,
  input  logic signed [COORD_BITS-1:0]  cx_i,
  input  logic signed [COORD_BITS-1:0]  cy_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [COORD_BITS-1:0]  span_x_o,
  output logic signed [COORD_BITS-1:0]  span_y_o,
  output logic [COORD_BITS-1:0]         span_width_o,
  output logic [tsr_pkg::COLOR_W-1:0]   span_color_o,
  output logic                          last_span_o,
  output logic                          done_res_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned XW = CW + 2;
  localparam int unsigned EW = CW + 4;
  localparam int unsigned NW = EW - 1;
  localparam int unsigned SW = CW + 1;

  function automatic logic signed [EW-1:0] edge_init(
    input logic signed [CW-1:0] xs,
    input logic signed [CW-1:0] ys,
    input logic signed [CW-1:0] xe,
    input logic signed [CW-1:0] ye
  );
    logic signed [DW-1:0] ddx;
    logic signed [DW-1:0] ddy;
    logic signed [EW-1:0] r;
    ddx = DW'(xe) - DW'(xs);
    ddy = DW'(ye) - DW'(ys);
    if (xe >= xs) begin
      r = EW'(ddy) - EW'(ddx);
    end else begin
      r = -EW'(ddy) - EW'(ddx);
    end
    return r;
  endfunction

  logic signed [CW-1:0]        v0x_q, v0y_q, v1x_q, v1y_q, v2x_q, v2y_q;
  logic signed [CW-1:0]        v0x_d, v0y_d, v1x_d, v1y_d, v2x_d, v2y_d;
  logic [tsr_pkg::COLOR_W-1:0] fill_color_q, fill_color_d;
  logic signed [XW-1:0]        lx_q, lx_d, rx_q, rx_d;
  logic signed [EW-1:0]        le_q, le_d, re_q, re_d;
  logic signed [CW-1:0]        row_q, row_d;
  tsr_pkg::phase_e             phase_q, phase_d;

  logic signed [CW-1:0]        res_x_q, res_x_d, res_y_q, res_y_d;
  logic [CW-1:0]               res_w_q, res_w_d;
  logic                        res_last_q, res_last_d, res_done_q, res_done_d;

  logic                        out_valid_q, out_valid_d;
  logic signed [CW-1:0]        out_x_q, out_y_q;
  logic [CW-1:0]               out_w_q;
  logic [tsr_pkg::COLOR_W-1:0] out_color_q;
  logic                        out_last_q, out_done_q;

  logic                        upper;
  logic signed [CW-1:0]        l_xs, l_xe, l_ys, l_ye;
  logic signed [CW-1:0]        w_xs, w_xe, w_ys, w_ye;
  logic signed [XW-1:0]        w_x;
  logic signed [EW-1:0]        w_e;
  logic signed [DW-1:0]        w_dy;
  logic [SW-1:0]               w_s;
  logic                        w_inc, w_neg;
  logic [NW-1:0]               w_num;
  logic [NW-1:0]               a_q;
  logic [SW-1:0]               a_r;
  logic signed [XW-1:0]        n_step;
  logic signed [XW-1:0]        x_new;
  logic signed [EW-1:0]        s_e, r_e, e_new;
  logic signed [DW-1:0]        ldx, rdx;
  logic signed [XW:0]          xdiff;
  logic [XW:0]                 xabs;

  logic                        div_done;
  logic [NW-1:0]               div_quo;
  logic [SW-1:0]               div_rem;

  tsr_div #(
    .NUM_W(NW),
    .DEN_W(SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctl_i.div_start),
    .num_i  (w_num),
    .den_i  (w_s),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // Left edge runs v0 to v1 in the upper half, v1 to v2 in the lower half
  assign upper = (phase_q == tsr_pkg::PH_UPPER);
  assign l_xs  = upper ? v0x_q : v1x_q;
  assign l_xe  = upper ? v1x_q : v2x_q;
  assign l_ys  = upper ? v0y_q : v1y_q;
  assign l_ye  = upper ? v1y_q : v2y_q;

  always_comb begin
    if (ctl_i.walk_edge == tsr_pkg::EDGE_RIGHT) begin
      w_xs = v0x_q;
      w_xe = v2x_q;
      w_ys = v0y_q;
      w_ye = v2y_q;
      w_x  = rx_q;
      w_e  = re_q;
    end else begin
      w_xs = l_xs;
      w_xe = l_xe;
      w_ys = l_ys;
      w_ye = l_ye;
      w_x  = lx_q;
      w_e  = le_q;
    end
  end

  // Steps needed: floor(num / 2dy) + 1, num = -e-1 when rising, e when falling
  assign w_inc  = (w_xe >= w_xs);
  assign w_dy   = DW'(w_ye) - DW'(w_ys);
  assign w_s    = {w_dy[CW-1:0], 1'b0};
  assign w_neg  = w_e[EW-1];
  assign w_num  = w_neg ? ~w_e[NW-1:0] : w_e[NW-1:0];

  assign a_q    = ctl_i.walk_div ? div_quo : '0;
  assign a_r    = ctl_i.walk_div ? div_rem : w_num[SW-1:0];
  assign n_step = XW'(a_q) + XW'(1);
  assign x_new  = w_inc ? (w_x + n_step) : (w_x - n_step);
  assign s_e    = EW'(w_s);
  assign r_e    = EW'(a_r);
  assign e_new  = w_inc ? (s_e - r_e - EW'(1)) : (r_e - s_e);

  assign ldx    = DW'(l_xe) - DW'(l_xs);
  assign rdx    = DW'(v2x_q) - DW'(v0x_q);
  assign xdiff  = (XW+1)'(rx_q) - (XW+1)'(lx_q);
  assign xabs   = xdiff[XW] ? (-xdiff) : xdiff;

  always_comb begin
    v0x_d        = v0x_q;
    v0y_d        = v0y_q;
    v1x_d        = v1x_q;
    v1y_d        = v1y_q;
    v2x_d        = v2x_q;
    v2y_d        = v2y_q;
    fill_color_d = fill_color_q;
    lx_d         = lx_q;
    rx_d         = rx_q;
    le_d         = le_q;
    re_d         = re_q;
    row_d        = row_q;
    phase_d      = phase_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    res_w_d      = res_w_q;
    res_last_d   = res_last_q;
    res_done_d   = res_done_q;

    if (ctl_i.load_start) begin
      v0x_d        = ax_i;
      v0y_d        = ay_i;
      v1x_d        = bx_i;
      v1y_d        = by_i;
      v2x_d        = cx_i;
      v2y_d        = cy_i;
      fill_color_d = color_i;
    end

    if (ctl_i.swap_en) begin
      case (ctl_i.swap_pair)
        tsr_pkg::PAIR_01: begin
          if (v1y_q < v0y_q) begin
            v0x_d = v1x_q; v0y_d = v1y_q;
            v1x_d = v0x_q; v1y_d = v0y_q;
          end
        end
        tsr_pkg::PAIR_02: begin
          if (v2y_q < v0y_q) begin
            v0x_d = v2x_q; v0y_d = v2y_q;
            v2x_d = v0x_q; v2y_d = v0y_q;
          end
        end
        tsr_pkg::PAIR_12: begin
          if (v2y_q < v1y_q) begin
            v1x_d = v2x_q; v1y_d = v2y_q;
            v2x_d = v1x_q; v2y_d = v1y_q;
          end
        end
        default: ;
      endcase
    end

    if (ctl_i.init) begin
      rx_d  = XW'(v0x_q);
      re_d  = edge_init(v0x_q, v0y_q, v2x_q, v2y_q);
      row_d = v0y_q;
      if (v0y_q < v1y_q) begin
        lx_d    = XW'(v0x_q);
        le_d    = edge_init(v0x_q, v0y_q, v1x_q, v1y_q);
        phase_d = tsr_pkg::PH_UPPER;
      end else begin
        lx_d    = XW'(v1x_q);
        le_d    = edge_init(v1x_q, v1y_q, v2x_q, v2y_q);
        phase_d = (v0y_q < v2y_q) ? tsr_pkg::PH_LOWER : tsr_pkg::PH_IDLE;
      end
    end

    if (ctl_i.walk_fast || ctl_i.walk_div) begin
      if (ctl_i.walk_edge == tsr_pkg::EDGE_RIGHT) begin
        rx_d = x_new;
        re_d = e_new;
      end else begin
        lx_d = x_new;
        le_d = e_new;
      end
    end

    if (ctl_i.advance) begin
      res_x_d    = (lx_q < rx_q) ? lx_q[CW-1:0] : rx_q[CW-1:0];
      res_y_d    = row_q;
      res_w_d    = xabs[CW-1:0];
      res_done_d = 1'b0;
      le_d       = le_q - (EW'(ldx) + EW'(ldx));
      re_d       = re_q - (EW'(rdx) + EW'(rdx));
      row_d      = row_q + CW'(1);
    end

    if (ctl_i.phase_step) begin
      if (upper) begin
        if (row_q >= v1y_q) begin
          lx_d    = XW'(v1x_q);
          le_d    = edge_init(v1x_q, v1y_q, v2x_q, v2y_q);
          phase_d = (row_q < v2y_q) ? tsr_pkg::PH_LOWER : tsr_pkg::PH_IDLE;
        end
      end else if (row_q >= v2y_q) begin
        phase_d = tsr_pkg::PH_IDLE;
      end
      res_last_d = (phase_d == tsr_pkg::PH_IDLE);
    end

    if (ctl_i.stage_done) begin
      res_x_d    = '0;
      res_y_d    = '0;
      res_w_d    = '0;
      res_last_d = 1'b0;
      res_done_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tsr_pkg::PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v0x_q        <= v0x_d;
    v0y_q        <= v0y_d;
    v1x_q        <= v1x_d;
    v1y_q        <= v1y_d;
    v2x_q        <= v2x_d;
    v2y_q        <= v2y_d;
    fill_color_q <= fill_color_d;
    lx_q         <= lx_d;
    rx_q         <= rx_d;
    le_q         <= le_d;
    re_q         <= re_d;
    row_q        <= row_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    res_w_q      <= res_w_d;
    res_last_q   <= res_last_d;
    res_done_q   <= res_done_d;
    if (ctl_i.emit) begin
      out_x_q     <= res_x_q;
      out_y_q     <= res_y_q;
      out_w_q     <= res_w_q;
      out_color_q <= res_done_q ? '0 : fill_color_q;
      out_last_q  <= res_last_q;
      out_done_q  <= res_done_q;
    end
  end

  assign stat_o.active    = (phase_q != tsr_pkg::PH_IDLE);
  assign stat_o.need_walk = w_inc ? w_neg : ~w_neg;
  assign stat_o.fast      = (w_num < NW'(w_s));
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign span_x_o     = out_x_q;
  assign span_y_o     = out_y_q;
  assign span_width_o = out_w_q;
  assign span_color_o = out_color_q;
  assign last_span_o  = out_last_q;
  assign done_res_o   = out_done_q;

endmodule

### hw/rtl/triangle_span_raster_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster unit
// Scanline triangle fill: a start item loads three vertices and a colour
// index; each span item returns one horizontal span of the triangle.
//
// Usage:
//   cmd_i  takes items; cmd = 0 starts a triangle, cmd = 1 asks for a span.
//   span_o returns one item per span request and none per start. With no
//          triangle pending the item has done_res set and all else zero;
//          last_span marks the final span of a triangle.
// Steps:
//   start: sort in three compare/exchange steps, then edge set-up.
//   span:  an edge that moves by less than one divisor step is walked
//          directly; each edge that jumps further runs the shared
//          restoring divider.
//   done:  staged straight from idle, with no edge walk.
//   One item is in work at a time; cmd_i.ready is high whenever the
//   controller is idle.
// Reset clears the controller, divider and output valid; no triangle is
// pending. A stalled result sits in the output register and the next item
// is still accepted; its result waits until the register frees.
// ----------------------------------------------------------------------------
module triangle_span_raster_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsr_cmd_if.sink   cmd_i,
  tsr_span_if.source span_o
);

  tsr_pkg::tsr_ctl_t  ctl;
  tsr_pkg::tsr_stat_t stat;
  logic               in_ready;

  tsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(cmd_i.valid),
    .in_cmd_i  (cmd_i.cmd),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  tsr_dpath #(
    .COORD_BITS(COORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .color_i     (cmd_i.color),
    .ax_i        (cmd_i.ax),
    .ay_i        (cmd_i.ay),
    .bx_i        (cmd_i.bx),
    .by_i        (cmd_i.by_coord),
    .cx_i        (cmd_i.cx),
    .cy_i        (cmd_i.cy),
    .out_ready_i (span_o.ready),
    .out_valid_o (span_o.valid),
    .span_x_o    (span_o.span_x),
    .span_y_o    (span_o.span_y),
    .span_width_o(span_o.span_width),
    .span_color_o(span_o.span_color),
    .last_span_o (span_o.last_span),
    .done_res_o  (span_o.done_res)
  );

  assign cmd_i.ready = in_ready;

endmodule

### hw/rtl/tsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster: port checker
// Tracks span requests against delivered items and checks result coding.
// ----------------------------------------------------------------------------
module tsr_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_cmd_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [COORD_BITS-1:0]  span_x_i,
  input logic signed [COORD_BITS-1:0]  span_y_i,
  input logic [COORD_BITS-1:0]         span_width_i,
  input logic [tsr_pkg::COLOR_W-1:0]   span_color_i,
  input logic                          last_span_i,
  input logic                          done_res_i
);

  logic [1:0] pending_q, pending_d;
  logic       req;
  logic       del;

  assign req = in_valid_i && in_ready_i && (in_cmd_i == tsr_pkg::CMD_SPAN);
  assign del = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (req && !del && (pending_q != 2'd3)) begin
      pending_d = pending_q + 2'd1;
    end else if (!req && del && (pending_q != 2'd0)) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(span_x_i) &&
      $stable(span_y_i) && $stable(span_width_i) && $stable(done_res_i))
    else $error("span item changed while stalled");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> span_x_i == '0 && span_y_i == '0 &&
      span_width_i == '0 && span_color_i == '0 && !last_span_i)
    else $error("done item carries span data");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("span item without a request");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd2 |-> !in_ready_i)
    else $error("item accepted with a result still waiting and one in work");

endmodule

bind triangle_span_raster_unit tsr_checker #(
  .COORD_BITS(COORD_BITS)
) u_tsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .in_cmd_i    (cmd_i.cmd),
  .out_valid_i (span_o.valid),
  .out_ready_i (span_o.ready),
  .span_x_i    (span_o.span_x),
  .span_y_i    (span_o.span_y),
  .span_width_i(span_o.span_width),
  .span_color_i(span_o.span_color),
  .last_span_i (span_o.last_span),
  .done_res_i  (span_o.done_res)
);

### sim/tb_triangle_span_raster_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle span raster unit testbench
// Drives start and span items through the command channel and checks every
// returned span against a scanline predictor. A short table covers sorting,
// a flat upper half, a degenerate triangle, coordinate extremes and a restart
// while busy. Random triangles follow, each with its run of span requests.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_triangle_span_raster_unit;

  localparam int unsigned CW = 16;
  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        color;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by_coord;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } cmd_item_t;

  typedef struct packed {
    cmd_item_t item;
    logic      want_done;
  } dir_row_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        width;
    logic [7:0]         color;
    logic               last;
    logic               done;
  } span_t;

  typedef enum {SINK_FREE, SINK_RANDOM, SINK_SLOW, SINK_CRAWL} sink_mode_e;

  localparam int unsigned DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // span with nothing pending after reset
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
    // unsorted vertices, full colour mask
    '{'{tsr_pkg::CMD_START, 8'hff, -16'sd4, 16'sd4, 16'sd10, 16'sd2, 16'sd0, 16'sd0},
      1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
    // flat upper half
    '{'{tsr_pkg::CMD_START, 8'h00, 16'sd0, 16'sd0, 16'sd8, 16'sd0, 16'sd4, 16'sd3},
      1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
    // degenerate: all on one row
    '{'{tsr_pkg::CMD_START, 8'h80, 16'sh8000, 16'sd5, 16'sh7fff, 16'sd5, 16'sd0, 16'sd5},
      1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
    // full-width span at the bottom of the coordinate range
    '{'{tsr_pkg::CMD_START, 8'h01, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
        16'sd0, 16'sh8002}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
    // top of the range, then dropped by a new start
    '{'{tsr_pkg::CMD_START, 8'h5a, 16'sh7fff, 16'sh7ffd, 16'sh8000, 16'sh7fff,
        16'sd0, 16'sh7ff8}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    // equal y on two vertices: no exchange on ties
    '{'{tsr_pkg::CMD_START, 8'hc3, 16'sd5, 16'sd1, 16'sd1, 16'sd3, 16'sd9, 16'sd1},
      1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0},
    '{'{tsr_pkg::CMD_SPAN, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1}
  };

  logic clk_i;
  logic rst_ni;

  tsr_cmd_if  #(.COORD_BITS(CW)) cmd_bus ();
  tsr_span_if #(.COORD_BITS(CW)) span_bus ();

  triangle_span_raster_unit #(
    .COORD_BITS(CW)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .span_o (span_bus)
  );

  // predictor state
  longint          tri_x [3] = '{0, 0, 0};
  longint          tri_y [3] = '{0, 0, 0};
  logic [7:0]      tri_color = 8'h00;
  longint          left_pos  = 0;
  longint          right_pos = 0;
  longint          left_err  = 0;
  longint          right_err = 0;
  longint          scan_row  = 0;
  tsr_pkg::phase_e tri_phase = tsr_pkg::PH_IDLE;

  span_t       pending_spans [$];
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint edge_setup(longint xs, longint ys, longint xe, longint ye);
    if (xe >= xs) return (ye - ys) - (xe - xs);
    return -(ye - ys) - (xe - xs);
  endfunction

  function automatic void edge_catch_up(inout longint pos, inout longint err,
                                        input longint xs, input longint xe,
                                        input longint dy);
    longint stride;
    longint n;
    stride = 2 * dy;
    if (xe >= xs) begin
      if (err < 0) begin
        n = (-err + stride - 1) / stride;
        pos += n;
        err += n * stride;
      end
    end else if (err >= 0) begin
      n = err / stride + 1;
      pos -= n;
      err -= n * stride;
    end
  endfunction

  function automatic void swap_vertices(int a, int b);
    longint tx;
    longint ty;
    tx = tri_x[a];
    ty = tri_y[a];
    tri_x[a] = tri_x[b];
    tri_y[a] = tri_y[b];
    tri_x[b] = tx;
    tri_y[b] = ty;
  endfunction

  function automatic void begin_lower_half();
    left_pos = tri_x[1];
    left_err = edge_setup(tri_x[1], tri_y[1], tri_x[2], tri_y[2]);
    tri_phase = (scan_row < tri_y[2]) ? tsr_pkg::PH_LOWER : tsr_pkg::PH_IDLE;
  endfunction

  // returns 1 when the item yields a span item
  function automatic bit predict_span(input cmd_item_t c, output span_t s);
    longint xs;
    longint xe;
    longint dy;
    longint lo;
    longint w;
    s = '0;
    if (c.cmd == tsr_pkg::CMD_START) begin
      tri_color = c.color;
      tri_x[0] = longint'($signed(c.ax));
      tri_y[0] = longint'($signed(c.ay));
      tri_x[1] = longint'($signed(c.bx));
      tri_y[1] = longint'($signed(c.by_coord));
      tri_x[2] = longint'($signed(c.cx));
      tri_y[2] = longint'($signed(c.cy));
      if (tri_y[1] < tri_y[0]) swap_vertices(1, 0);
      if (tri_y[2] < tri_y[0]) swap_vertices(2, 0);
      if (tri_y[2] < tri_y[1]) swap_vertices(2, 1);
      left_pos  = tri_x[0];
      right_pos = tri_x[0];
      left_err  = edge_setup(tri_x[0], tri_y[0], tri_x[1], tri_y[1]);
      right_err = edge_setup(tri_x[0], tri_y[0], tri_x[2], tri_y[2]);
      scan_row  = tri_y[0];
      if (scan_row < tri_y[1]) tri_phase = tsr_pkg::PH_UPPER;
      else begin_lower_half();
      return 1'b0;
    end
    if (tri_phase != tsr_pkg::PH_UPPER && tri_phase != tsr_pkg::PH_LOWER) begin
      s.done = 1'b1;
      return 1'b1;
    end
    if (tri_phase == tsr_pkg::PH_UPPER) begin
      xs = tri_x[0];
      xe = tri_x[1];
      dy = tri_y[1] - tri_y[0];
    end else begin
      xs = tri_x[1];
      xe = tri_x[2];
      dy = tri_y[2] - tri_y[1];
    end
    edge_catch_up(left_pos, left_err, xs, xe, dy);
    edge_catch_up(right_pos, right_err, tri_x[0], tri_x[2], tri_y[2] - tri_y[0]);
    lo = (left_pos < right_pos) ? left_pos : right_pos;
    w  = right_pos - left_pos;
    if (w < 0) w = -w;
    s.x     = lo[15:0];
    s.y     = scan_row[15:0];
    s.width = w[15:0];
    s.color = tri_color;
    left_err  -= 2 * (xe - xs);
    right_err -= 2 * (tri_x[2] - tri_x[0]);
    scan_row++;
    if (tri_phase == tsr_pkg::PH_UPPER) begin
      if (scan_row >= tri_y[1]) begin_lower_half();
    end else if (scan_row >= tri_y[2]) begin
      tri_phase = tsr_pkg::PH_IDLE;
    end
    s.last = (tri_phase == tsr_pkg::PH_IDLE);
    return 1'b1;
  endfunction

  function automatic string span_text(span_t s);
    return $sformatf("x=%0d y=%0d w=%0d colour=%0d last=%0b done=%0b",
                     s.x, s.y, s.width, s.color, s.last, s.done);
  endfunction

  // called right after an accepting edge; returns at the next accepting edge
  task automatic send_cmd(input cmd_item_t c, input logic want_done);
    int unsigned gap;
    span_t       s;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.cmd      <= c.cmd;
    cmd_bus.color    <= c.color;
    cmd_bus.ax       <= c.ax;
    cmd_bus.ay       <= c.ay;
    cmd_bus.bx       <= c.bx;
    cmd_bus.by_coord <= c.by_coord;
    cmd_bus.cx       <= c.cx;
    cmd_bus.cy       <= c.cy;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (predict_span(c, s)) begin
      if (want_done) begin
        s = '0;
        s.done = 1'b1;
      end
      pending_spans.push_back(s);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_x(int unsigned mode, int base);
    logic signed [15:0] corner [4];
    corner = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
    case (mode)
      0: return 16'($urandom);
      1: return 16'(base + int'($urandom_range(0, 100)) - 50);
      default: return corner[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic cmd_item_t noise_span();
    cmd_item_t c;
    c.cmd      = tsr_pkg::CMD_SPAN;
    c.color    = 8'($urandom);
    c.ax       = 16'($urandom);
    c.ay       = 16'($urandom);
    c.bx       = 16'($urandom);
    c.by_coord = 16'($urandom);
    c.cx       = 16'($urandom);
    c.cy       = 16'($urandom);
    return c;
  endfunction

  initial begin : stimulus
    cmd_item_t   c;
    int unsigned x_mode;
    int unsigned n_spans;
    int          x_base;
    int          y_base;
    int          spread;
    int          ys [3];
    int          y_lo;
    int          y_hi;
    bit          short_rows;

    cmd_bus.valid    = 1'b0;
    cmd_bus.cmd      = tsr_pkg::CMD_SPAN;
    cmd_bus.color    = '0;
    cmd_bus.ax       = '0;
    cmd_bus.ay       = '0;
    cmd_bus.bx       = '0;
    cmd_bus.by_coord = '0;
    cmd_bus.cx       = '0;
    cmd_bus.cy       = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_cmd(DIRECTED[i].item, DIRECTED[i].want_done);
    hold_until_drained();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) hold_until_drained();
      short_rows = ($urandom_range(0, 4) != 0);
      x_mode = ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(0, 1);
      x_base = int'($urandom_range(50, 65535 - 50)) - 32768;
      c.cmd   = tsr_pkg::CMD_START;
      c.color = 8'($urandom);
      c.ax = pick_x(x_mode, x_base);
      c.bx = pick_x(x_mode, x_base);
      c.cx = pick_x(x_mode, x_base);
      if (short_rows) begin
        spread = $urandom_range(0, 12);
        y_base = int'($urandom_range(0, 65535 - 12)) - 32768;
        foreach (ys[k]) ys[k] = y_base + int'($urandom_range(0, spread));
        y_lo = ys[0];
        y_hi = ys[0];
        foreach (ys[k]) begin
          if (ys[k] < y_lo) y_lo = ys[k];
          if (ys[k] > y_hi) y_hi = ys[k];
        end
        n_spans = ($urandom_range(0, 5) == 0) ? $urandom_range(0, y_hi - y_lo)
                                               : y_hi - y_lo + $urandom_range(0, 2);
      end else begin
        foreach (ys[k]) ys[k] = int'($urandom_range(0, 65535)) - 32768;
        n_spans = $urandom_range(1, 6);
      end
      c.ay       = 16'(ys[0]);
      c.by_coord = 16'(ys[1]);
      c.cy       = 16'(ys[2]);
      send_cmd(c, 1'b0);
      for (int unsigned k = 0; k < n_spans && items_sent < ITEM_TARGET; k++) begin
        send_cmd(noise_span(), 1'b0);
      end
    end

    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_spans.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : span_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned tick;
    logic        take;
    span_bus.ready = 1'b0;
    mode = SINK_FREE;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        SINK_FREE:   take = 1'b1;
        SINK_RANDOM: take = 1'($urandom_range(0, 1));
        SINK_SLOW:   take = (tick % 3) != 0;
        default:     take = (tick % 8) == 0;
      endcase
      span_bus.ready <= take;
    end
  end

  always @(posedge clk_i) begin : span_check
    span_t got;
    span_t want;
    if (rst_ni && span_bus.valid && span_bus.ready) begin
      got.x     = span_bus.span_x;
      got.y     = span_bus.span_y;
      got.width = span_bus.span_width;
      got.color = span_bus.span_color;
      got.last  = span_bus.last_span;
      got.done  = span_bus.done_res;
      if (pending_spans.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) $display("unexpected span item: %s", span_text(got));
      end else begin
        want = pending_spans.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.width !== want.width ||
            got.color !== want.color || got.last !== want.last || got.done !== want.done)
        begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("span mismatch: expected %s, actual %s", span_text(want), span_text(got));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
